// ----- src/calendar_clock_with_prescaler_defines.svh -----
// Assertion macros shared by the calendar clock RTL
`ifndef CALENDAR_CLOCK_WITH_PRESCALER_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_PRESCALER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define CCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ccp_pkg.sv -----
// Types, constants and calendar helper functions for the calendar clock
package ccp_pkg;

	localparam int YEAR_BITS = 16;

	localparam logic [2:0] CFG_MINUTE_LENGTH = 3'd0;
	localparam logic [2:0] CFG_START_YEAR    = 3'd1;
	localparam logic [2:0] CFG_START_MONTH   = 3'd2;
	localparam logic [2:0] CFG_START_DAY     = 3'd3;
	localparam logic [2:0] CFG_START_HOUR    = 3'd4;
	localparam logic [2:0] CFG_START_MINUTE  = 3'd5;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [31:0] MINUTE_LENGTH_RST = 32'd1000;
	localparam logic [15:0] START_YEAR_RST    = 16'd2000;
	localparam logic [3:0]  START_MONTH_RST   = 4'd1;
	localparam logic [4:0]  START_DAY_RST     = 5'd1;
	localparam logic [4:0]  START_HOUR_RST    = 5'd0;
	localparam logic [5:0]  START_MINUTE_RST  = 6'd0;

	typedef struct packed {
		logic        cmd;
		logic [15:0] elapsed;
	} in_t;

	typedef struct packed {
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [15:0] year;
		logic [8:0]  day_of_year;
		logic        time_updated;
		logic        hour_rolled;
		logic        day_rolled;
		logic        month_rolled;
		logic        year_rolled;
	} out_t;

	typedef struct packed {
		logic [31:0] minute_length;
		logic [15:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
	} cfg_t;

	// Inverse of an odd number modulo 2^64 by Newton steps (bits double each step)
	function automatic logic [63:0] inv_mod2k(input logic [63:0] a);
		logic [63:0] x;
		x = a;
		for (int i = 0; i < 5; i++) begin
			x = x * (64'd2 - a * x);
		end
		return x;
	endfunction

	localparam logic [YEAR_BITS-1:0] YEAR_INV25 = YEAR_BITS'(inv_mod2k(64'd25));
	localparam logic [YEAR_BITS-1:0] YEAR_DIV25_MAX =
		YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

	// Leap rule 4/100/400; divisible by 400 is divisible by 16 and 25 together
	function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
		logic [YEAR_BITS-1:0] p;
		logic                 by25;
		p    = YEAR_BITS'(y * YEAR_INV25);
		by25 = (p <= YEAR_DIV25_MAX);
		return (y[1:0] == 2'b00) && (!by25 || (y[3:0] == 4'b0000));
	endfunction

	// Zero for an invalid month: the day then never rolls over
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- src/ccp_cfg_regs.sv -----
// Configuration register file of the calendar clock
module ccp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_wdata,
	output ccp_pkg::cfg_t cfg
);
	import ccp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.minute_length <= MINUTE_LENGTH_RST;
			cfg_q.start_year    <= START_YEAR_RST;
			cfg_q.start_month   <= START_MONTH_RST;
			cfg_q.start_day     <= START_DAY_RST;
			cfg_q.start_hour    <= START_HOUR_RST;
			cfg_q.start_minute  <= START_MINUTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MINUTE_LENGTH: cfg_q.minute_length <= cfg_wdata;
				CFG_START_YEAR:    cfg_q.start_year    <= cfg_wdata[15:0];
				CFG_START_MONTH:   cfg_q.start_month   <= cfg_wdata[3:0];
				CFG_START_DAY:     cfg_q.start_day     <= cfg_wdata[4:0];
				CFG_START_HOUR:    cfg_q.start_hour    <= cfg_wdata[4:0];
				CFG_START_MINUTE:  cfg_q.start_minute  <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/ccp_prescaler.sv -----
// Minute prescaler: residual counter with reload and floor
module ccp_prescaler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [15:0] elapsed,
	input  logic [31:0] minute_length,
	output logic        adv
);
	import ccp_pkg::*;

	logic [32:0] residual_q;
	logic [33:0] res_x;
	logic [33:0] diff;
	logic [33:0] reload;
	logic [33:0] r;
	logic        floor_hit;
	logic [32:0] residual_d;

	// 34-bit two's complement holds the residual minus a full elapsed count
	assign res_x  = {residual_q[32], residual_q};
	assign diff   = res_x - {18'b0, elapsed};
	assign reload = res_x + {2'b0, minute_length} - {18'b0, elapsed};
	assign adv    = diff[33] || (diff == '0);
	assign r      = adv ? reload : diff;

	// Below -2^32: bit 33 set, bit 32 clear
	assign floor_hit  = r[33] && !r[32];
	assign residual_d = floor_hit ? {1'b1, 32'b0} : r[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residual_q <= {1'b0, MINUTE_LENGTH_RST};
		end else if (en) begin
			residual_q <= residual_d;
		end
	end

endmodule

// ----- src/ccp_calendar.sv -----
// Calendar state: minute to year cascade and load from the start registers
module ccp_calendar (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          cmd,
	input  logic          adv,
	input  ccp_pkg::cfg_t cfg,
	output ccp_pkg::out_t res
);
	import ccp_pkg::*;

	logic [5:0]           minute_q, minute_d;
	logic [4:0]           hour_q, hour_d;
	logic [4:0]           day_q, day_d;
	logic [3:0]           month_q, month_d;
	logic [YEAR_BITS-1:0] year_q, year_d;
	logic [8:0]           doy_q, doy_d;

	logic                 upd, hr, dr, mr, yr;
	logic [YEAR_BITS-1:0] ld_year;
	logic                 ld_leap;
	logic                 cur_leap;
	logic [4:0]           cur_len;
	logic [5:0]           day_inc;

	assign ld_year  = YEAR_BITS'(cfg.start_year);
	assign ld_leap  = is_leap(ld_year);
	assign cur_leap = is_leap(year_q);
	assign cur_len  = month_len(month_q, cur_leap);
	assign day_inc  = {1'b0, day_q} + 6'd1;

	always_comb begin
		minute_d = minute_q;
		hour_d   = hour_q;
		day_d    = day_q;
		month_d  = month_q;
		year_d   = year_q;
		doy_d    = doy_q;
		upd      = 1'b0;
		hr       = 1'b0;
		dr       = 1'b0;
		mr       = 1'b0;
		yr       = 1'b0;
		if (cmd == CMD_LOAD) begin
			upd      = 1'b1;
			minute_d = cfg.start_minute;
			hour_d   = cfg.start_hour;
			day_d    = cfg.start_day;
			month_d  = cfg.start_month;
			year_d   = ld_year;
			if (cfg.start_month >= 4'd1 && cfg.start_month <= 4'd12) begin
				doy_d = days_before(cfg.start_month) + {4'b0, cfg.start_day}
					+ {8'b0, (cfg.start_month >= 4'd3) && ld_leap};
			end else begin
				doy_d = 9'd0;
			end
		end else if (adv) begin
			upd = 1'b1;
			if (minute_q >= 6'd59) begin
				minute_d = 6'd0;
				hr       = 1'b1;
			end else begin
				minute_d = minute_q + 6'd1;
			end
			if (hr) begin
				if (hour_q >= 5'd23) begin
					hour_d = 5'd0;
					dr     = 1'b1;
				end else begin
					hour_d = hour_q + 5'd1;
				end
			end
			if (dr) begin
				doy_d = doy_q + 9'd1;
				day_d = day_inc[4:0];
				// An invalid month has zero length and never rolls over
				if (cur_len != 5'd0 && day_inc > {1'b0, cur_len}) begin
					day_d = 5'd1;
					mr    = 1'b1;
					if (month_q >= 4'd12) begin
						month_d = 4'd1;
						yr      = 1'b1;
						year_d  = year_q + YEAR_BITS'(1);
						doy_d   = 9'd1;
					end else begin
						month_d = month_q + 4'd1;
					end
				end
			end
		end
	end

	always_comb begin
		res.minute       = minute_d;
		res.hour         = hour_d;
		res.day_of_month = day_d;
		res.month        = month_d;
		res.year         = 16'(year_d);
		res.day_of_year  = doy_d;
		res.time_updated = upd;
		res.hour_rolled  = hr;
		res.day_rolled   = dr;
		res.month_rolled = mr;
		res.year_rolled  = yr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minute_q <= 6'd0;
			hour_q   <= 5'd0;
			day_q    <= 5'd1;
			month_q  <= 4'd1;
			year_q   <= YEAR_BITS'(START_YEAR_RST);
			doy_q    <= 9'd1;
		end else if (en) begin
			minute_q <= minute_d;
			hour_q   <= hour_d;
			day_q    <= day_d;
			month_q  <= month_d;
			year_q   <= year_d;
			doy_q    <= doy_d;
		end
	end

endmodule

// ----- src/calendar_clock_with_prescaler.sv -----
// Top level of the prescaled Gregorian calendar clock
//
//   port group  direction  handshake             beat contents
//   in_*        in         in_valid / in_stall   ccp_pkg::in_t  (cmd, elapsed)
//   out_*       out        out_valid / out_stall ccp_pkg::out_t (time, day of year, flags)
//   cfg_*       in         cfg_we                register index and 32-bit data
//
// One beat per cycle sustained while out_stall is low; a beat is registered in the input
// stage, then its result in the output register as the residual and calendar registers update.
// Reset is asynchronous: clock at year 2000, month 1, day 1, 00:00, residual 1000.
// A stalled result holds in the output register; the input stage takes one more
// beat and then raises in_stall until the output register frees.
`include "calendar_clock_with_prescaler_defines.svh"

module calendar_clock_with_prescaler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ccp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output ccp_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_wdata
);
	import ccp_pkg::*;

	cfg_t cfg;
	in_t  in_s1;
	logic valid_s1;
	out_t res_s2;
	logic valid_s2;
	out_t res;
	logic adv;
	logic s2_ready;
	logic fire_s1;
	logic in_fire;

	assign s2_ready = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;
	assign in_fire  = in_valid && !in_stall;

	ccp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ccp_prescaler u_presc (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (fire_s1 && (in_s1.cmd == CMD_TICK)),
		.elapsed       (in_s1.elapsed),
		.minute_length (cfg.minute_length),
		.adv           (adv)
	);

	ccp_calendar u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire_s1),
		.cmd    (in_s1.cmd),
		.adv    (adv),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_s1 <= in_data;
		end
	end

	// Drop the result once taken, load the next one as the state advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	`CCP_ASSERT_IMP(a_hour_roll, clk, arst_n, valid_s2 && res_s2.hour_rolled, res_s2.minute == 6'd0 && res_s2.time_updated, "hour roll without minute wrap")
	`CCP_ASSERT_IMP(a_day_roll, clk, arst_n, valid_s2 && res_s2.day_rolled, res_s2.hour_rolled && res_s2.hour == 5'd0, "day roll without hour wrap")
	`CCP_ASSERT_IMP(a_month_roll, clk, arst_n, valid_s2 && res_s2.month_rolled, res_s2.day_rolled && res_s2.day_of_month == 5'd1, "month roll without day wrap")
	`CCP_ASSERT_IMP(a_year_roll, clk, arst_n, valid_s2 && res_s2.year_rolled, res_s2.month_rolled && res_s2.month == 4'd1 && res_s2.day_of_year == 9'd1, "year roll without new year")

endmodule
